### rtl/core/dfp_pkg.sv
package dfp_pkg;

  localparam int MAX_FIELD_WIDTH = 80;
  localparam int POS_W = $clog2(MAX_FIELD_WIDTH + 1);
  localparam int CFG_W = 7;
  localparam int VAL_W = 64;

  localparam logic [VAL_W-1:0] MAG_LIMIT = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(10);

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Parse phases
  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_NUM  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;
  localparam logic [1:0] PH_BAD  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [1:0]       phase;
    logic             neg;
    logic [VAL_W-1:0] acc;
    logic [1:0]       pend;
  } dfp_state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [1:0]              status;
  } dfp_result_t;

  localparam dfp_state_t FIELD_CLEAR = '{
    pos: '0, phase: PH_LEAD, neg: 1'b0, acc: '0, pend: ST_OK
  };

  // Largest magnitude that may still take digit d without passing MAG_LIMIT
  function automatic logic [VAL_W-1:0] digit_limit(input logic [3:0] d);
    logic [VAL_W-1:0] lim;
    unique case (d)
      4'd0:    lim = (MAG_LIMIT - 64'd0) / 10;
      4'd1:    lim = (MAG_LIMIT - 64'd1) / 10;
      4'd2:    lim = (MAG_LIMIT - 64'd2) / 10;
      4'd3:    lim = (MAG_LIMIT - 64'd3) / 10;
      4'd4:    lim = (MAG_LIMIT - 64'd4) / 10;
      4'd5:    lim = (MAG_LIMIT - 64'd5) / 10;
      4'd6:    lim = (MAG_LIMIT - 64'd6) / 10;
      4'd7:    lim = (MAG_LIMIT - 64'd7) / 10;
      4'd8:    lim = (MAG_LIMIT - 64'd8) / 10;
      4'd9:    lim = (MAG_LIMIT - 64'd9) / 10;
      default: lim = '0;
    endcase
    return lim;
  endfunction

  function automatic dfp_result_t field_result(input dfp_state_t s);
    dfp_result_t r;
    r.value  = '0;
    r.status = s.pend;
    if (s.phase == PH_LEAD) begin
      r.status = ST_EMPTY;
    end else if (s.pend == ST_INVALID) begin
      r.status = ST_INVALID;
    end else begin
      r.value = s.neg ? $signed(VAL_W'(0) - s.acc) : $signed(s.acc);
    end
    return r;
  endfunction

endpackage

### rtl/core/dfp_in_reg.sv
module dfp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       take,
  output logic       hold_valid,
  output logic [7:0] hold_char
);

  logic       valid_r, valid_nxt;
  logic [7:0] char_r;

  assign in_tready  = !valid_r || take;
  assign hold_valid = valid_r;
  assign hold_char  = char_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      char_r <= in_tdata;
    end
  end

endmodule

### rtl/core/dfp_core.sv
module dfp_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           take,
  input  logic [7:0]                     char_i,
  input  logic                           cfg_we,
  input  logic [dfp_pkg::CFG_W-1:0]      cfg_wdata,
  output logic                           emit,
  output dfp_pkg::dfp_result_t           res
);
  import dfp_pkg::*;

  logic [CFG_W-1:0] width_r;
  dfp_state_t       st_r, st_nxt, work;
  logic [7:0]       wide_w, eff8;
  logic [POS_W-1:0] eff_w, pos_inc;
  logic             digit;
  logic [3:0]       d;
  logic [VAL_W-1:0] acc_x10;

  // Width 0 acts as 1, above the maximum acts as the maximum
  assign wide_w = 8'(width_r);
  always_comb begin
    if (wide_w == 8'd0) begin
      eff8 = 8'd1;
    end else if (wide_w > 8'(MAX_FIELD_WIDTH)) begin
      eff8 = 8'(MAX_FIELD_WIDTH);
    end else begin
      eff8 = wide_w;
    end
  end
  assign eff_w = POS_W'(eff8);

  assign digit   = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign d       = char_i[3:0];
  assign acc_x10 = (st_r.acc << 3) + (st_r.acc << 1) + VAL_W'(d);
  assign pos_inc = st_r.pos + POS_W'(1);

  always_comb begin
    work = st_r;
    unique case (st_r.phase)
      PH_LEAD: begin
        if (char_i == CH_SPACE) begin
          work.phase = PH_LEAD;
        end else if (char_i == CH_MINUS) begin
          work.neg   = 1'b1;
          work.phase = PH_NUM;
        end else if (digit) begin
          work.acc   = VAL_W'(d);
          work.phase = PH_NUM;
        end else begin
          work.phase = PH_BAD;
          work.pend  = ST_INVALID;
        end
      end
      PH_NUM: begin
        if (digit) begin
          if (st_r.acc > digit_limit(d)) begin
            work.acc  = MAG_LIMIT;
            work.pend = ST_OVERFLOW;
          end else begin
            work.acc  = acc_x10;
          end
        end else if (char_i == CH_SPACE) begin
          work.phase = PH_DONE;
        end else begin
          work.phase = PH_BAD;
          work.pend  = ST_INVALID;
        end
      end
      default: begin
        work.phase = st_r.phase;
      end
    endcase
    work.pos = pos_inc;
  end

  always_comb begin
    emit   = 1'b0;
    res    = field_result(work);
    st_nxt = work;
    if (char_i == CH_NUL) begin
      // End of card: flush a started field, always restart
      emit   = (st_r.pos != '0);
      res    = field_result(st_r);
      st_nxt = FIELD_CLEAR;
    end else if (pos_inc >= eff_w) begin
      emit   = 1'b1;
      st_nxt = FIELD_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
      st_r    <= FIELD_CLEAR;
    end else begin
      if (cfg_we) begin
        width_r <= cfg_wdata;
      end
      if (take) begin
        st_r <= st_nxt;
      end
    end
  end

endmodule

### rtl/core/dfp_out_reg.sv
module dfp_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  dfp_pkg::dfp_result_t   res,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [63:0]            out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   slot_free
);
  import dfp_pkg::*;

  logic        valid_r, valid_nxt;
  dfp_result_t res_r;

  assign slot_free  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.value;
  assign out_tuser  = res_r.status;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

### rtl/core/fixed_width_decimal_field_parser.sv
// An accepted input beat is held in the input holding register, then stepped
// through the digit multiply-add into the result register, which drives out_tvalid.
// Throughput: one character beat per cycle while the result register is free;
// at most one result beat per input beat.
// Reset (rst_n low, synchronous): both channels empty, field state cleared,
// field width back to 10.
module fixed_width_decimal_field_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  // Character stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] character
  // Field results
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [63:0]                 out_tdata,  // [63:0] value (signed)
  output logic [1:0]                  out_tuser,  // [1:0] status
  // Field width register
  input  logic                        cfg_we,
  input  logic [dfp_pkg::CFG_W-1:0]   cfg_wdata   // [6:0] field_width
);
  import dfp_pkg::*;

  logic        hold_valid;
  logic [7:0]  hold_char;
  logic        slot_free;
  logic        take;
  logic        emit;
  dfp_result_t res;

  // Advance the held character only when the result register can take
  // whatever it produces; this keeps one beat per cycle under no stall.
  assign take = hold_valid && slot_free;

  dfp_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_char  (hold_char)
  );

  // Field state machine: skip leading spaces, take sign and digits,
  // saturate on overflow, flag any other character as invalid, close the field at the width or at NUL.
  dfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .char_i    (hold_char),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .emit      (emit),
    .res       (res)
  );

  // Result register: holds a finished field while downstream stalls.
  dfp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take && emit),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .slot_free  (slot_free)
  );

endmodule

### rtl/core/dfp_checker.sv
module dfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import dfp_pkg::*;

  // Stalled result beat must hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Empty and invalid fields carry zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY || out_tuser == ST_INVALID) |-> out_tdata == 64'd0)
    else $error("error status with non-zero value");

  // Overflow saturates to plus or minus the largest magnitude
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OVERFLOW |->
      out_tdata == 64'h7FFF_FFFF_FFFF_FFFF || out_tdata == 64'h8000_0000_0000_0001)
    else $error("overflow value not saturated");

  // Magnitude never reaches 2^63
  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != 64'h8000_0000_0000_0000)
    else $error("value out of range");

  // Both channels empty after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("channel not empty straight after reset");

endmodule

bind fixed_width_decimal_field_parser dfp_checker u_dfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
